// ===== design/dcc_pkg.sv =====
package dcc_pkg;

    localparam int CPUS_PER_NODE = 2;
    localparam int ADDR_SUM_W    = 15;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] ST_UNCACHED = 2'd0;
    localparam logic [1:0] ST_SHARED   = 2'd1;
    localparam logic [1:0] ST_DIRTY    = 2'd3;

    typedef enum logic [2:0] {
        K_LOCAL   = 3'd0,
        K_SISTER  = 3'd1,
        K_HOME    = 3'd2,
        K_DIRTY   = 3'd3,
        K_ST_HIT  = 3'd4,
        K_ST_MISS = 3'd5
    } kind_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_HIT   = 2'd0,
        CFG_SISTER_HIT  = 2'd1,
        CFG_HOME_MEMORY = 2'd2,
        CFG_DIRTY_REM   = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_LOOKUP,
        S_CHECK,
        S_VIC_RD,
        S_VIC_WB,
        S_SIS_CHK,
        S_DRT_CHK0,
        S_DRT_CHK1,
        S_DRT_DONE,
        S_FILL,
        S_INV_RD,
        S_INV_CHK,
        S_ST_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  node_id;
        logic        cpu_id;
        logic        cmd;
        logic [4:0]  base_value;
        logic [4:0]  reg_field;
        logic [15:0] byte_offset;
    } in_t;

    typedef struct packed {
        logic [31:0] load_data;
        logic [2:0]  service_kind;
        logic [7:0]  cost_charged;
        logic [31:0] total_cost;
        logic        address_error;
    } out_t;

endpackage

// ===== design/dcc_ram.sv =====
module dcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/dcc_addr_dec.sv =====
module dcc_addr_dec #(
    parameter int TOTAL_WORDS = 64,
    parameter int CACHE_LINES = 4
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [dcc_pkg::ADDR_SUM_W-1:0]         addr,
    output logic [$clog2(CACHE_LINES)-1:0]         idx,
    output logic [((TOTAL_WORDS + CACHE_LINES - 1) / CACHE_LINES > 1 ?
                   $clog2((TOTAL_WORDS + CACHE_LINES - 1) / CACHE_LINES) : 1)-1:0] tag,
    output logic                                   err
);
    import dcc_pkg::*;

    localparam int AWD  = $clog2(TOTAL_WORDS);
    localparam int IDXW = $clog2(CACHE_LINES);
    localparam int TAGN = (TOTAL_WORDS + CACHE_LINES - 1) / CACHE_LINES;
    localparam int TAGW = TAGN > 1 ? $clog2(TAGN) : 1;
    localparam int SH   = AWD + 7;
    localparam int RCP  = (2 ** SH) / CACHE_LINES;
    localparam int PW   = AWD + SH;

    logic [AWD-1:0]  x1_reg;
    logic [AWD-1:0]  q1_reg;
    logic [PW-1:0]   prod;
    logic [IDXW:0]   rem;
    logic            fix;

    // reciprocal estimate is low by at most one
    assign prod = PW'(addr[AWD-1:0]) * PW'(RCP);

    always_ff @(posedge clk) begin
        if (en) begin
            x1_reg <= addr[AWD-1:0];
            q1_reg <= AWD'(prod >> SH);
            err    <= addr >= ADDR_SUM_W'(TOTAL_WORDS);
        end
    end

    assign rem = (IDXW+1)'(32'(x1_reg) - 32'(q1_reg) * CACHE_LINES);
    assign fix = 32'(rem) >= CACHE_LINES;

    always_ff @(posedge clk) begin
        tag <= fix ? TAGW'(q1_reg + AWD'(1)) : TAGW'(q1_reg);
        idx <= fix ? IDXW'(32'(rem) - CACHE_LINES) : IDXW'(rem);
    end
endmodule

// ===== design/directory_coherence_controller.sv =====
// Directory coherence controller: serves one load or store per item for a
// system of NODES nodes, two CPUs each, with direct-mapped caches and a
// per-word directory.
// Channels: s_valid/s_ready/s_data carries one access item; m_valid/m_ready/
// m_data returns one result item per access. cfg_valid/cfg_ready/cfg_index/
// cfg_data writes the four cost registers; cfg_ready is always high.
// A load miss writes back a dirty victim if there is one, then tries the
// sister line before home memory or a dirty remote fetch. A store walks
// the candidate lines of every node through the single cache RAM read
// port to invalidate sharer copies; a store hit then writes its new data.
// One item is in flight at a time.
// Reset: a clearing pass over max(NODES*WORDS_PER_NODE, NODES*2*CACHE_LINES)
// entries (64 at default sizes) loads memory with address+5 and clears the
// directory and cache lines; s_ready stays low during it.
// Stall: the result sits in an output register; the next item may be
// accepted and worked on, but it holds at its last step until that
// register is taken.
module directory_coherence_controller #(
    parameter int NODES          = 4,
    parameter int CACHE_LINES    = 4,
    parameter int WORDS_PER_NODE = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dcc_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dcc_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import dcc_pkg::*;

    localparam int TOTAL  = NODES * WORDS_PER_NODE;
    localparam int AWD    = $clog2(TOTAL);
    localparam int NW     = $clog2(NODES);
    localparam int IDXW   = $clog2(CACHE_LINES);
    localparam int TAGN   = (TOTAL + CACHE_LINES - 1) / CACHE_LINES;
    localparam int TAGW   = TAGN > 1 ? $clog2(TAGN) : 1;
    localparam int VAW    = TAGW + IDXW;
    localparam int NLINES = NODES * CPUS_PER_NODE * CACHE_LINES;
    localparam int LAW    = $clog2(NLINES);
    localparam int LW     = 1 + TAGW + 32;
    localparam int DW     = 2 + NODES;
    localparam int NREGS  = NODES * CPUS_PER_NODE * 2;
    localparam int RFW    = $clog2(NREGS);
    localparam int CLRN   = TOTAL > NLINES ? TOTAL : NLINES;
    localparam int CW     = $clog2(CLRN);
    localparam int JW     = $clog2(2 * NODES);

    state_t state_reg, state_next;

    // cost registers
    logic [7:0] local_cost_reg, sister_cost_reg, home_cost_reg, dirty_cost_reg;

    // latched request
    logic [NW-1:0]  node_reg;
    logic           cpu_reg, cmd_reg, rsel_reg;
    logic [AWD-1:0] addr_reg;

    // captured RAM reads and working values
    logic [LW-1:0]  loc_reg, loc_next;
    logic [DW-1:0]  dirv_reg, dirv_next;
    logic [31:0]    memd_reg, memd_next;
    logic [31:0]    dat_reg, dat_next;
    kind_e_t        kind_reg, kind_next;
    logic [7:0]     cost_reg, cost_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [CW-1:0]  clr_reg, clr_next;
    logic [31:0]    total_reg;
    logic           out_valid_reg;
    out_t           out_reg;
    logic           out_load;

    logic [31:0]    rf_reg [NREGS];
    logic           rf_we;
    logic [RFW-1:0] rf_idx;
    logic [31:0]    rf_rdata;

    // RAM ports
    logic           dir_we, mem_we, c_we;
    logic [AWD-1:0] dir_waddr, dir_raddr, mem_waddr, mem_raddr;
    logic [DW-1:0]  dir_wdata, dir_rdata;
    logic [31:0]    mem_wdata, mem_rdata;
    logic [LAW-1:0] c_waddr, c_raddr;
    logic [LW-1:0]  c_wdata, c_rdata;

    // address decode
    logic [ADDR_SUM_W-1:0] s_addr;
    logic [IDXW-1:0]       idx_dec;
    logic [TAGW-1:0]       tag_dec;
    logic                  err_dec;
    logic                  accept;
    logic [31:0]           node_full;

    // derived conditions
    logic                  rd_hit;
    logic [LAW-1:0]        line_loc, line_sis, line_fs0, line_fs1, line_j;
    logic [VAW-1:0]        va_full;
    logic                  va_ok;
    logic [NW-1:0]         fs_node;
    logic                  fs_any;
    logic [NODES-1:0]      node_bit;
    logic [NODES-1:0]      dir_sh, rd_sh;
    logic [1:0]            dir_st, rd_st;
    logic                  j_last;

    function automatic logic [LAW-1:0] line_at(input logic [NW-1:0] n, input logic c,
                                               input logic [IDXW-1:0] i);
        return LAW'((32'(n) * CPUS_PER_NODE + 32'(c)) * CACHE_LINES + 32'(i));
    endfunction

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign s_addr    = ADDR_SUM_W'(s_data.base_value) + ADDR_SUM_W'(s_data.byte_offset >> 2);
    // node_id is below twice NODES, so one subtract folds it
    assign node_full = (32'(s_data.node_id) >= NODES) ? 32'(s_data.node_id) - NODES
                                                       : 32'(s_data.node_id);

    dcc_addr_dec #(
        .TOTAL_WORDS(TOTAL),
        .CACHE_LINES(CACHE_LINES)
    ) u_dec (
        .clk (aclk),
        .en  (accept),
        .addr(s_addr),
        .idx (idx_dec),
        .tag (tag_dec),
        .err (err_dec)
    );

    dcc_ram #(.WIDTH(DW), .DEPTH(TOTAL)) u_dir_ram (
        .clk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rdata)
    );

    dcc_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_mem_ram (
        .clk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    dcc_ram #(.WIDTH(LW), .DEPTH(NLINES)) u_cache_ram (
        .clk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // line {valid, tag, data}; directory {status, sharers}
    assign rd_hit   = c_rdata[LW-1] && (c_rdata[32 +: TAGW] == tag_dec);
    assign line_loc = line_at(node_reg, cpu_reg, idx_dec);
    assign line_sis = line_at(node_reg, ~cpu_reg, idx_dec);
    assign line_fs0 = line_at(fs_node, 1'b0, idx_dec);
    assign line_fs1 = line_at(fs_node, 1'b1, idx_dec);
    assign line_j   = line_at(j_reg[JW-1:1], j_reg[0], idx_dec);
    assign va_full  = VAW'(32'(loc_reg[32 +: TAGW]) * CACHE_LINES + 32'(idx_dec));
    assign va_ok    = 32'(va_full) < TOTAL;
    assign node_bit = NODES'(1) << node_reg;
    assign dir_st   = dirv_reg[DW-1 -: 2];
    assign dir_sh   = dirv_reg[NODES-1:0];
    assign rd_st    = dir_rdata[DW-1 -: 2];
    assign rd_sh    = dir_rdata[NODES-1:0];
    assign j_last   = (j_reg == JW'(2 * NODES - 1));
    assign rf_idx   = RFW'((32'(node_reg) * CPUS_PER_NODE + 32'(cpu_reg)) * 2 + 32'(rsel_reg));
    assign rf_rdata = rf_reg[rf_idx];

    // lowest sharer node
    always_comb begin
        fs_node = '0;
        fs_any  = 1'b0;
        for (int n = NODES - 1; n >= 0; n--) begin
            if (dir_sh[n]) begin
                fs_node = NW'(n);
                fs_any  = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == CW'(CLRN - 1)) state_next = S_IDLE;
            S_IDLE:     if (accept) state_next = S_DEC;
            S_DEC:      state_next = S_LOOKUP;
            S_LOOKUP:   state_next = err_dec ? S_FINISH : S_CHECK;
            S_CHECK: begin
                if (cmd_reg) state_next = S_INV_RD;
                else if (rd_hit) state_next = S_FILL;
                else if (c_rdata[LW-1]) state_next = S_VIC_RD;
                else state_next = S_SIS_CHK;
            end
            S_VIC_RD:   state_next = S_VIC_WB;
            S_VIC_WB:   state_next = S_SIS_CHK;
            S_SIS_CHK: begin
                if (rd_hit || dir_st != ST_DIRTY) state_next = S_FILL;
                else if (fs_any) state_next = S_DRT_CHK0;
                else state_next = S_DRT_DONE;
            end
            S_DRT_CHK0: state_next = rd_hit ? S_DRT_DONE : S_DRT_CHK1;
            S_DRT_CHK1: state_next = S_DRT_DONE;
            S_DRT_DONE: state_next = S_FILL;
            S_FILL:     state_next = S_FINISH;
            S_INV_RD: begin
                if (dir_sh[j_reg[JW-1:1]]) state_next = S_INV_CHK;
                else if (j_last) state_next = (kind_reg == K_ST_HIT) ? S_ST_WR : S_FINISH;
            end
            S_INV_CHK: begin
                if (j_last) state_next = (kind_reg == K_ST_HIT) ? S_ST_WR : S_FINISH;
                else state_next = S_INV_RD;
            end
            S_ST_WR:    state_next = S_FINISH;
            S_FINISH:   if (!out_valid_reg || m_ready) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
    end

    // RAM controls and datapath
    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = addr_reg;
        dir_wdata = dirv_reg;
        dir_raddr = addr_reg;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = dat_reg;
        mem_raddr = addr_reg;
        c_we      = 1'b0;
        c_waddr   = line_loc;
        c_wdata   = {1'b1, tag_dec, dat_reg};
        c_raddr   = line_loc;
        rf_we     = 1'b0;
        out_load  = 1'b0;
        loc_next  = loc_reg;
        dirv_next = dirv_reg;
        memd_next = memd_reg;
        dat_next  = dat_reg;
        kind_next = kind_reg;
        cost_next = cost_reg;
        j_next    = j_reg;
        clr_next  = clr_reg;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 32'(clr_reg) < TOTAL;
                mem_waddr = AWD'(clr_reg);
                mem_wdata = 32'(clr_reg) + 32'd5;
                dir_we    = 32'(clr_reg) < TOTAL;
                dir_waddr = AWD'(clr_reg);
                dir_wdata = '0;
                c_we      = 32'(clr_reg) < NLINES;
                c_waddr   = LAW'(clr_reg);
                c_wdata   = '0;
                clr_next  = clr_reg + CW'(1);
            end
            S_IDLE, S_DEC: begin
            end
            S_LOOKUP: begin
                kind_next = K_LOCAL;
                cost_next = '0;
                dat_next  = '0;
            end
            S_CHECK: begin
                loc_next  = c_rdata;
                dirv_next = dir_rdata;
                memd_next = mem_rdata;
                j_next    = '0;
                if (!cmd_reg) begin
                    if (rd_hit) begin
                        dat_next  = c_rdata[31:0];
                        kind_next = K_LOCAL;
                        cost_next = local_cost_reg;
                    end else if (!c_rdata[LW-1]) begin
                        c_raddr = line_sis;
                    end
                end else if (rd_hit) begin
                    dir_we    = 1'b1;
                    dir_wdata = {ST_DIRTY, rd_sh};
                    kind_next = K_ST_HIT;
                    cost_next = local_cost_reg;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = rf_rdata;
                    dir_we    = 1'b1;
                    dir_wdata = {(rd_st == ST_DIRTY) ? ST_SHARED : rd_st, rd_sh};
                    kind_next = K_ST_MISS;
                    cost_next = home_cost_reg;
                end
            end
            S_VIC_RD: begin
                dir_raddr = AWD'(va_full);
            end
            S_VIC_WB: begin
                // victim's directory status arrives now
                mem_we    = va_ok && (rd_st == ST_DIRTY);
                mem_waddr = AWD'(va_full);
                mem_wdata = loc_reg[31:0];
                c_raddr   = line_sis;
            end
            S_SIS_CHK: begin
                if (rd_hit) begin
                    dat_next  = c_rdata[31:0];
                    kind_next = K_SISTER;
                    cost_next = sister_cost_reg;
                end else if (dir_st != ST_DIRTY) begin
                    dat_next  = memd_reg;
                    dir_we    = 1'b1;
                    dir_wdata = {ST_SHARED, dir_sh | node_bit};
                    kind_next = K_HOME;
                    cost_next = home_cost_reg;
                end else begin
                    // dirty word: fall back to memory if no owner line matches
                    dat_next  = memd_reg;
                    kind_next = K_DIRTY;
                    cost_next = dirty_cost_reg;
                    c_raddr   = line_fs0;
                end
            end
            S_DRT_CHK0: begin
                if (rd_hit) dat_next = c_rdata[31:0];
                c_raddr = line_fs1;
            end
            S_DRT_CHK1: begin
                if (rd_hit) dat_next = c_rdata[31:0];
            end
            S_DRT_DONE: begin
                mem_we    = 1'b1;
                dir_we    = 1'b1;
                dir_wdata = {ST_SHARED, dir_sh | node_bit};
            end
            S_FILL: begin
                c_we  = 1'b1;
                rf_we = 1'b1;
            end
            S_INV_RD: begin
                c_raddr = line_j;
                if (!dir_sh[j_reg[JW-1:1]] && !j_last) j_next = j_reg + JW'(1);
            end
            S_INV_CHK: begin
                c_we    = rd_hit;
                c_waddr = line_j;
                c_wdata = {1'b0, c_rdata[LW-2:0]};
                if (!j_last) j_next = j_reg + JW'(1);
            end
            S_ST_WR: begin
                c_we    = 1'b1;
                c_wdata = {1'b1, tag_dec, rf_rdata};
            end
            S_FINISH: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            total_reg       <= '0;
            local_cost_reg  <= 8'd1;
            sister_cost_reg <= 8'd30;
            home_cost_reg   <= 8'd100;
            dirty_cost_reg  <= 8'd135;
            for (int r = 0; r < NREGS; r++) rf_reg[r] <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LOCAL_HIT:   local_cost_reg  <= cfg_data;
                    CFG_SISTER_HIT:  sister_cost_reg <= cfg_data;
                    CFG_HOME_MEMORY: home_cost_reg   <= cfg_data;
                    CFG_DIRTY_REM:   dirty_cost_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (rf_we) rf_reg[rf_idx] <= dat_reg;
            if (out_load) begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_reg + 32'(cost_reg);
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            node_reg <= NW'(node_full);
            cpu_reg  <= s_data.cpu_id;
            cmd_reg  <= s_data.cmd;
            rsel_reg <= ~s_data.reg_field[0];
            addr_reg <= s_addr[AWD-1:0];
        end
        loc_reg  <= loc_next;
        dirv_reg <= dirv_next;
        memd_reg <= memd_next;
        dat_reg  <= dat_next;
        kind_reg <= kind_next;
        cost_reg <= cost_next;
        j_reg    <= j_next;
        if (out_load) begin
            out_reg.load_data     <= (cmd_reg || err_dec) ? 32'd0 : dat_reg;
            out_reg.service_kind  <= kind_reg;
            out_reg.cost_charged  <= cost_reg;
            out_reg.total_cost    <= total_reg + 32'(cost_reg);
            out_reg.address_error <= err_dec;
        end
    end
endmodule

// ===== design/dcc_checker.sv =====
module dcc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input dcc_pkg::out_t m_data
);
    import dcc_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.address_error |->
            m_data.load_data == 32'd0 && m_data.cost_charged == 8'd0 &&
            m_data.service_kind == K_LOCAL)
        else $error("address error item carries data or cost");

    a_store_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.service_kind == K_ST_HIT || m_data.service_kind == K_ST_MISS)
            |-> m_data.load_data == 32'd0)
        else $error("store result carries load data");
endmodule

bind directory_coherence_controller dcc_checker u_dcc_checker (.*);

// ===== tb/sv/tb.sv =====
module tb;
    import dcc_pkg::*;

    localparam int NODES = 4;
    localparam int CACHE_LINES = 4;
    localparam int WORDS_PER_NODE = 16;
    localparam int TOTAL_WORDS = NODES * WORDS_PER_NODE;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    directory_coherence_controller uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the coherence system
    typedef struct {
        bit        valid;
        bit [31:0] tag;
        bit [31:0] data;
    } line_t;

    bit [7:0]  cost_tab [4];
    bit [31:0] regs [NODES][2][2];
    line_t     lines [NODES][2][CACHE_LINES];
    bit [31:0] mem [TOTAL_WORDS];
    bit [1:0]  dir_state [TOTAL_WORDS];
    bit [7:0]  dir_sharers [TOTAL_WORDS];
    bit [31:0] running_total;

    out_t pending_results[$];
    bit   failed = 1'b0;
    int   idle_cycles = 0;
    int   results_seen = 0;

    function automatic void reset_shadow();
        cost_tab[CFG_LOCAL_HIT] = 8'd1;
        cost_tab[CFG_SISTER_HIT] = 8'd30;
        cost_tab[CFG_HOME_MEMORY] = 8'd100;
        cost_tab[CFG_DIRTY_REM] = 8'd135;
        for (int n = 0; n < NODES; n++)
            for (int c = 0; c < 2; c++) begin
                regs[n][c][0] = '0;
                regs[n][c][1] = '0;
                for (int i = 0; i < CACHE_LINES; i++)
                    lines[n][c][i] = '{1'b0, 32'd0, 32'd0};
            end
        for (int a = 0; a < TOTAL_WORDS; a++) begin
            mem[a] = a + 5;
            dir_state[a] = ST_UNCACHED;
            dir_sharers[a] = '0;
        end
        running_total = '0;
    endfunction

    function automatic bit line_match(line_t l, bit [31:0] tag);
        return l.valid && l.tag == tag;
    endfunction

    function automatic void drop_sharer_copies(int addr, int idx, bit [31:0] tag);
        for (int n = 0; n < NODES; n++)
            if (dir_sharers[addr][n])
                for (int c = 0; c < 2; c++)
                    if (line_match(lines[n][c][idx], tag))
                        lines[n][c][idx].valid = 1'b0;
    endfunction

    // Perform one access on the shadow and return the result it must produce
    function automatic out_t serve_access(in_t acc);
        out_t r = '0;
        int node, cpu, rsel, addr, idx, first;
        bit [31:0] tag, val, va;
        bit found;
        line_t sis;
        node = acc.node_id % NODES;
        cpu = acc.cpu_id;
        rsel = acc.reg_field[0] ^ 1'b1;
        addr = acc.base_value + (acc.byte_offset >> 2);
        if (addr >= TOTAL_WORDS) begin
            r.total_cost = running_total;
            r.address_error = 1'b1;
            return r;
        end
        idx = addr % CACHE_LINES;
        tag = addr / CACHE_LINES;
        if (!acc.cmd) begin
            if (line_match(lines[node][cpu][idx], tag)) begin
                r.load_data = lines[node][cpu][idx].data;
                r.service_kind = K_LOCAL;
                r.cost_charged = cost_tab[CFG_LOCAL_HIT];
            end else begin
                sis = lines[node][cpu ^ 1][idx];
                // dirty victim goes back to memory before the fill
                if (lines[node][cpu][idx].valid) begin
                    va = lines[node][cpu][idx].tag * CACHE_LINES + idx;
                    if (va < TOTAL_WORDS && dir_state[va] == ST_DIRTY)
                        mem[va] = lines[node][cpu][idx].data;
                end
                if (line_match(sis, tag)) begin
                    r.load_data = sis.data;
                    r.service_kind = K_SISTER;
                    r.cost_charged = cost_tab[CFG_SISTER_HIT];
                end else if (dir_state[addr] != ST_DIRTY) begin
                    r.load_data = mem[addr];
                    dir_state[addr] = ST_SHARED;
                    dir_sharers[addr][node] = 1'b1;
                    r.service_kind = K_HOME;
                    r.cost_charged = cost_tab[CFG_HOME_MEMORY];
                end else begin
                    // fetch from lowest sharer node, falling back to memory
                    r.load_data = mem[addr];
                    first = NODES;
                    for (int n = NODES - 1; n >= 0; n--)
                        if (dir_sharers[addr][n]) first = n;
                    found = 1'b0;
                    if (first < NODES)
                        for (int c = 0; c < 2; c++)
                            if (!found && line_match(lines[first][c][idx], tag)) begin
                                r.load_data = lines[first][c][idx].data;
                                found = 1'b1;
                            end
                    mem[addr] = r.load_data;
                    dir_state[addr] = ST_SHARED;
                    dir_sharers[addr][node] = 1'b1;
                    r.service_kind = K_DIRTY;
                    r.cost_charged = cost_tab[CFG_DIRTY_REM];
                end
                lines[node][cpu][idx] = '{1'b1, tag, r.load_data};
            end
            regs[node][cpu][rsel] = r.load_data;
        end else begin
            val = regs[node][cpu][rsel];
            if (line_match(lines[node][cpu][idx], tag)) begin
                dir_state[addr] = ST_DIRTY;
                drop_sharer_copies(addr, idx, tag);
                lines[node][cpu][idx] = '{1'b1, tag, val};
                r.service_kind = K_ST_HIT;
                r.cost_charged = cost_tab[CFG_LOCAL_HIT];
            end else begin
                mem[addr] = val;
                drop_sharer_copies(addr, idx, tag);
                if (dir_state[addr] == ST_DIRTY) dir_state[addr] = ST_SHARED;
                r.service_kind = K_ST_MISS;
                r.cost_charged = cost_tab[CFG_HOME_MEMORY];
            end
            r.load_data = '0;
        end
        running_total += r.cost_charged;
        r.total_cost = running_total;
        return r;
    endfunction

    // Gap length: mostly zero or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, compare with oldest expectation
    int stall_left = 0;
    bit stall_on = 1'b1;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    failed <= 1'b1;
                end else begin
                    out_t e;
                    e = pending_results.pop_front();
                    if (m_data.load_data !== e.load_data)
                        $display("%0t: load_data exp %h got %h", $time, e.load_data,
                                 m_data.load_data);
                    if (m_data.service_kind !== e.service_kind)
                        $display("%0t: service_kind exp %0d got %0d", $time,
                                 e.service_kind, m_data.service_kind);
                    if (m_data.cost_charged !== e.cost_charged)
                        $display("%0t: cost_charged exp %0d got %0d", $time,
                                 e.cost_charged, m_data.cost_charged);
                    if (m_data.total_cost !== e.total_cost)
                        $display("%0t: total_cost exp %0d got %0d", $time,
                                 e.total_cost, m_data.total_cost);
                    if (m_data.address_error !== e.address_error)
                        $display("%0t: address_error exp %0b got %0b", $time,
                                 e.address_error, m_data.address_error);
                    if (m_data !== e) failed <= 1'b1;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** directory_coherence_controller: FAILED **");
            $finish;
        end
    end

    // valid drops at the accepting edge and rises again no earlier than the next one
    task automatic send_access(in_t acc, bit use_gap);
        int g;
        g = use_gap ? pick_gap() : 0;
        repeat (g + 1) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= acc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(serve_access(acc));
        s_valid <= 1'b0;
    endtask

    task automatic write_cost(cfg_idx_t idx, bit [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cost_tab[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every result has arrived, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic in_t make_access(bit [1:0] n, bit c, bit cmd, int addr, bit [4:0] rf);
        in_t a;
        int b;
        b = (addr > 31) ? 31 : addr;
        a.node_id = n;
        a.cpu_id = c;
        a.cmd = cmd;
        a.base_value = 5'(b);
        a.reg_field = rf;
        a.byte_offset = 16'((addr - b) * 4 + int'($urandom_range(0, 3)));
        return a;
    endfunction

    // Directed rows: fields plus an expected value where it is plain to see
    typedef struct {
        in_t  acc;
        bit   known;
        out_t res;
    } row_t;

    row_t rows[$];
    int   hot_addrs[4];

    initial begin
        in_t a;
        out_t r;
        reset_shadow();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset costs
        a = '{2'd0, 1'b0, 1'b0, 5'd0, 5'd1, 16'd0};
        rows.push_back('{a, 1'b1, '{32'd5, K_HOME, 8'd100, 32'd100, 1'b0}});
        a = '{2'd0, 1'b0, 1'b0, 5'd0, 5'd1, 16'd3};
        rows.push_back('{a, 1'b1, '{32'd5, K_LOCAL, 8'd1, 32'd101, 1'b0}});
        a = '{2'd0, 1'b1, 1'b0, 5'd0, 5'd0, 16'd0};
        rows.push_back('{a, 1'b1, '{32'd5, K_SISTER, 8'd30, 32'd131, 1'b0}});
        a = '{2'd3, 1'b1, 1'b0, 5'd31, 5'd31, 16'd128};
        rows.push_back('{a, 1'b1, '{32'd68, K_HOME, 8'd100, 32'd231, 1'b0}});
        a = '{2'd3, 1'b0, 1'b0, 5'd31, 5'd2, 16'd132};
        rows.push_back('{a, 1'b1, '{32'd0, K_LOCAL, 8'd0, 32'd231, 1'b1}});
        a = '{2'd1, 1'b1, 1'b1, 5'd31, 5'd7, 16'hFFFF};
        rows.push_back('{a, 1'b1, '{32'd0, K_LOCAL, 8'd0, 32'd231, 1'b1}});
        // store hit, then loads by other nodes, the first a dirty remote fetch
        a = '{2'd0, 1'b0, 1'b1, 5'd0, 5'd1, 16'd0};  rows.push_back('{a, 1'b0, '0});
        a = '{2'd2, 1'b0, 1'b0, 5'd0, 5'd3, 16'd0};  rows.push_back('{a, 1'b0, '0});
        a = '{2'd1, 1'b1, 1'b0, 5'd0, 5'd4, 16'd1};  rows.push_back('{a, 1'b0, '0});
        // store hit, then store misses
        a = '{2'd3, 1'b1, 1'b1, 5'd31, 5'd31, 16'd128}; rows.push_back('{a, 1'b0, '0});
        a = '{2'd2, 1'b1, 1'b1, 5'd5, 5'd0, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd0, 1'b1, 1'b1, 5'd0, 5'd0, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd3, 1'b0, 1'b1, 5'd4, 5'd1, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd3, 1'b0, 1'b1, 5'd4, 5'd1, 16'd0};   rows.push_back('{a, 1'b0, '0});
        // conflict miss evicting a dirty line, then reload
        a = '{2'd3, 1'b0, 1'b0, 5'd4, 5'd1, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd3, 1'b0, 1'b1, 5'd4, 5'd1, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd3, 1'b0, 1'b0, 5'd8, 5'd1, 16'd0};   rows.push_back('{a, 1'b0, '0});
        a = '{2'd1, 1'b0, 1'b0, 5'd4, 5'd30, 16'd0};  rows.push_back('{a, 1'b0, '0});
        a = '{2'd2, 1'b1, 1'b0, 5'd21, 5'd21, 16'hAAA8}; rows.push_back('{a, 1'b0, '0});

        foreach (rows[i]) begin
            r = serve_access(rows[i].acc);
            if (rows[i].known && r !== rows[i].res) begin
                $display("%0t: row %0d table exp %p model %p", $time, i, rows[i].res, r);
                failed = 1'b1;
            end
            // undo the shadow step; send_access applies it at accept time
            pending_results.push_back(r);
        end
        pending_results.delete();
        reset_shadow();
        foreach (rows[i]) send_access(rows[i].acc, $urandom_range(0, 1));
        drain();

        // Random phases across cost settings, extremes first
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 4; k++) begin
                bit [7:0] v;
                case (ph)
                    0: v = 8'd0;
                    1: v = 8'd255;
                    default: v = $urandom_range(0, 255);
                endcase
                write_cost(cfg_idx_t'(k), v);
            end
            stall_on = (ph != 2);
            for (int h = 0; h < 4; h++) hot_addrs[h] = $urandom_range(0, TOTAL_WORDS - 1);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
                int p;
                p = $urandom_range(0, 99);
                if (p < 70) begin
                    // sharing traffic on a few hot words and their conflicts
                    int ad;
                    ad = hot_addrs[$urandom_range(0, 3)];
                    if ($urandom_range(0, 3) == 0)
                        ad = (ad + CACHE_LINES * $urandom_range(1, 3)) % TOTAL_WORDS;
                    a = make_access(2'($urandom), 1'($urandom),
                                    $urandom_range(0, 99) < 40, ad, 5'($urandom));
                end else if (p < 90) begin
                    a = make_access(2'($urandom), 1'($urandom), 1'($urandom),
                                    $urandom_range(0, 63), 5'($urandom));
                end else begin
                    a = in_t'($urandom);
                end
                send_access(a, ph != 3);
            end
            drain();
        end

        stall_on = 1'b0;
        drain();
        if (!failed && pending_results.size() == 0)
            $display("** directory_coherence_controller: PASSED **");
        else
            $display("** directory_coherence_controller: FAILED **");
        $finish;
    end
endmodule
